@@ hdl/pea_pkg.sv @@
// shared types, codes and constants for the page extent allocator
package pea_pkg;

	// field widths of the item and result ports
	localparam int OP_W         = 2;
	localparam int FIRST_PAGE_W = 6;
	localparam int PAGE_COUNT_W = 7;
	localparam int STATUS_W     = 2;

	// default page store size and reset value of active pages
	localparam int DEF_MAX_PAGES = 64;
	localparam int ACTIVE_RESET  = 64;

	// most runs a single allocate may return
	localparam int MAX_RUNS = 32;

	// request codes
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 2'd0,
		OP_ALLOC_AT = 2'd1,
		OP_FREE     = 2'd2,
		OP_CHECK    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_WRONG    = 2'd2,
		ST_NO_SPACE = 2'd3
	} status_t;

	// kind of result written into the output register
	typedef enum logic [2:0] {
		PUT_NONE,
		PUT_ZERO,
		PUT_NO_SPACE,
		PUT_RANGE,
		PUT_RUN,
		PUT_GROUP
	} put_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take_item;   // latch the input item
		logic load_walk;   // copy the map into the walk copy, reset run count
		logic charge;      // take the requested pages off the free count
		logic find;        // register the lowest run of the walk copy
		logic step;        // consume the registered run
		logic group_scan;  // register the group mask and offending pages
		put_t put;         // result to write into the output register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic no_space;
		logic out_of_range;
		logic run_last;
		logic too_many;
		logic slot_free;
	} sts_t;

endpackage

@@ hdl/page_extent_allocator.sv @@
// top level of the page extent allocator: controller and datapath
// First-fit page allocator over a map of MAX_PAGES pages with a free count. One request is
// taken at a time; in_stall stays high from acceptance until the request's final result has
// been written into the output register, so the next request is accepted while that result
// still waits on out_stall. An allocate alternates between finding the lowest run of free
// pages and consuming it and emitting its result, once for each returned run; with more than
// 64 pages a run count pass over the same steps comes first. Zero-sized, no-space and
// out-of-range requests are answered from decode, group requests (allocate-at, free, check)
// after a group scan. Writing active_pages frees every page below it at once.
module page_extent_allocator import pea_pkg::*; #(
	parameter int MAX_PAGES = DEF_MAX_PAGES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    active_pages_we,
	input  logic [PAGE_COUNT_W-1:0] active_pages,
	// request channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [OP_W-1:0]         op,
	input  logic [FIRST_PAGE_W-1:0] first_page,
	input  logic [PAGE_COUNT_W-1:0] page_count,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [FIRST_PAGE_W-1:0] group_first,
	output logic [PAGE_COUNT_W-1:0] group_count,
	output logic [FIRST_PAGE_W-1:0] bad_page,
	output logic [PAGE_COUNT_W-1:0] free_left,
	output logic                    last
);

	cmd_t cmd;
	sts_t sts;

	// sequencing of requests
	pea_ctrl #(
		.MAX_PAGES(MAX_PAGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// page map and result generation
	pea_datapath #(
		.MAX_PAGES(MAX_PAGES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (active_pages_we),
		.cfg_active  (active_pages),
		.op          (op),
		.first_page  (first_page),
		.page_count  (page_count),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.group_first (group_first),
		.group_count (group_count),
		.bad_page    (bad_page),
		.free_left   (free_left),
		.last        (last)
	);

endmodule

@@ hdl/pea_ctrl.sv @@
// controller state machine of the page extent allocator
module pea_ctrl import pea_pkg::*; #(
	parameter int MAX_PAGES = DEF_MAX_PAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	// a run count pass is needed only when more runs than allowed can exist
	localparam bit CHECK_RUNS = (MAX_PAGES > 2 * MAX_RUNS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_CNT_FIND,
		S_CNT_STEP,
		S_CNT_END,
		S_EM_FIND,
		S_EM_STEP,
		S_GRP_RES
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall_q;

	assign in_stall = stall_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.put = PUT_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op == OP_ALLOC) begin
					if (sts.cnt_zero) begin
						if (sts.slot_free) begin
							cmd.put = PUT_ZERO;
							state_d = S_IDLE;
						end
					end else if (sts.no_space) begin
						if (sts.slot_free) begin
							cmd.put = PUT_NO_SPACE;
							state_d = S_IDLE;
						end
					end else begin
						cmd.load_walk = 1'b1;
						if (CHECK_RUNS) begin
							state_d = S_CNT_FIND;
						end else begin
							cmd.charge = 1'b1;
							state_d    = S_EM_FIND;
						end
					end
				end else begin
					if (sts.cnt_zero) begin
						if (sts.slot_free) begin
							cmd.put = PUT_ZERO;
							state_d = S_IDLE;
						end
					end else if (sts.out_of_range) begin
						if (sts.slot_free) begin
							cmd.put = PUT_RANGE;
							state_d = S_IDLE;
						end
					end else begin
						cmd.group_scan = 1'b1;
						state_d        = S_GRP_RES;
					end
				end
			end
			S_CNT_FIND: begin
				cmd.find = 1'b1;
				state_d  = S_CNT_STEP;
			end
			S_CNT_STEP: begin
				cmd.step = 1'b1;
				state_d  = sts.run_last ? S_CNT_END : S_CNT_FIND;
			end
			S_CNT_END: begin
				if (sts.too_many) begin
					if (sts.slot_free) begin
						cmd.put = PUT_NO_SPACE;
						state_d = S_IDLE;
					end
				end else begin
					cmd.load_walk = 1'b1;
					cmd.charge    = 1'b1;
					state_d       = S_EM_FIND;
				end
			end
			S_EM_FIND: begin
				cmd.find = 1'b1;
				state_d  = S_EM_STEP;
			end
			S_EM_STEP: begin
				if (sts.slot_free) begin
					cmd.step = 1'b1;
					cmd.put  = PUT_RUN;
					state_d  = sts.run_last ? S_IDLE : S_EM_FIND;
				end
			end
			S_GRP_RES: begin
				if (sts.slot_free) begin
					cmd.put = PUT_GROUP;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and stall register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stall_q <= (state_d != S_IDLE);
		end
	end

endmodule

@@ hdl/pea_datapath.sv @@
// page map, free count, run finder and result register of the page extent allocator
module pea_datapath import pea_pkg::*; #(
	parameter int MAX_PAGES = DEF_MAX_PAGES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [PAGE_COUNT_W-1:0] cfg_active,
	// item payload
	input  logic [OP_W-1:0]         op,
	input  logic [FIRST_PAGE_W-1:0] first_page,
	input  logic [PAGE_COUNT_W-1:0] page_count,
	// controller link
	input  cmd_t                    cmd,
	output sts_t                    sts,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [FIRST_PAGE_W-1:0] group_first,
	output logic [PAGE_COUNT_W-1:0] group_count,
	output logic [FIRST_PAGE_W-1:0] bad_page,
	output logic [PAGE_COUNT_W-1:0] free_left,
	output logic                    last
);

	localparam int PW  = $clog2(MAX_PAGES);
	localparam int CW  = $clog2(MAX_PAGES + 1);
	localparam int KW  = (CW > PAGE_COUNT_W) ? CW : PAGE_COUNT_W;
	localparam int RW  = $clog2(MAX_PAGES / 2 + 2);
	localparam int RESET_ACTIVE = (ACTIVE_RESET > MAX_PAGES) ? MAX_PAGES : ACTIVE_RESET;
	localparam logic [MAX_PAGES-1:0] ONE_P = {{(MAX_PAGES-1){1'b0}}, 1'b1};
	localparam logic [MAX_PAGES-1:0] RESET_MAP =
		{MAX_PAGES{1'b1}} >> (MAX_PAGES - RESET_ACTIVE);

	// index of the set bit of a one-hot vector
	function automatic logic [PW-1:0] onehot_idx(input logic [MAX_PAGES-1:0] v);
		logic [PW-1:0] idx;
		idx = '0;
		for (int i = 0; i < MAX_PAGES; i++) begin
			if (v[i]) idx = idx | PW'(i);
		end
		return idx;
	endfunction

	// persistent state
	logic [MAX_PAGES-1:0]    map_q;
	logic [KW-1:0]           free_q;
	logic [KW-1:0]           active_q;

	// latched item
	op_t                     op_q;
	logic [FIRST_PAGE_W-1:0] first_q;
	logic [KW-1:0]           cnt_q;

	// allocation walk
	logic [MAX_PAGES-1:0]    work_q;
	logic [KW-1:0]           left_q;
	logic [RW-1:0]           runs_q;
	logic [MAX_PAGES-1:0]    runm_q;
	logic [PW-1:0]           start_q;
	logic [KW-1:0]           len_q;

	// group check
	logic [MAX_PAGES-1:0]    gmask_q;
	logic [MAX_PAGES-1:0]    offend_q;

	// result register
	logic                    out_valid_q;
	status_t                 status_q;
	logic [FIRST_PAGE_W-1:0] gfirst_q;
	logic [PAGE_COUNT_W-1:0] gcount_q;
	logic [FIRST_PAGE_W-1:0] bad_q;
	logic [PAGE_COUNT_W-1:0] free_left_q;
	logic                    last_q;

	// configuration decode
	logic [KW-1:0]           cfg_n;
	logic [MAX_PAGES-1:0]    cfg_map;

	always_comb begin
		cfg_n = (KW'(cfg_active) > KW'(MAX_PAGES)) ? KW'(MAX_PAGES) : KW'(cfg_active);
		for (int p = 0; p < MAX_PAGES; p++) begin
			cfg_map[p] = (KW'(p) < cfg_n);
		end
	end

	// request checks
	logic [KW-1:0] first_k;
	logic          cnt_zero;
	logic          no_space;
	logic          out_of_range;

	assign first_k      = KW'(first_q);
	assign cnt_zero     = (cnt_q == '0);
	assign no_space     = (cnt_q > free_q);
	assign out_of_range = (first_k >= active_q) || (cnt_q > active_q - first_k);

	// group mask and offending pages
	logic [MAX_PAGES-1:0] gmask;
	logic [MAX_PAGES-1:0] offend_scan;

	always_comb begin
		gmask       = ((ONE_P << cnt_q) - ONE_P) << first_q;
		offend_scan = (op_q == OP_ALLOC_AT) ? (~map_q & gmask) : (map_q & gmask);
	end

	// lowest offending page and group update
	logic [MAX_PAGES-1:0] offend_low;
	logic                 offend_any;
	logic [PW-1:0]        bad_idx;
	logic [KW-1:0]        free_grp;
	logic [MAX_PAGES-1:0] map_grp;

	always_comb begin
		offend_low = offend_q & (~offend_q + ONE_P);
		offend_any = |offend_q;
		bad_idx    = onehot_idx(offend_low);
		free_grp   = free_q;
		map_grp    = map_q;
		if (!offend_any) begin
			case (op_q)
				OP_ALLOC_AT: begin
					free_grp = free_q - cnt_q;
					map_grp  = map_q & ~gmask_q;
				end
				OP_FREE: begin
					free_grp = free_q + cnt_q;
					map_grp  = map_q | gmask_q;
				end
				default: begin
					free_grp = free_q;
					map_grp  = map_q;
				end
			endcase
		end
	end

	// lowest run of free pages in the walk copy
	logic [MAX_PAGES-1:0] carry;
	logic [MAX_PAGES-1:0] run_mask;
	logic [MAX_PAGES-1:0] run_low;
	logic [MAX_PAGES-1:0] end_oh;
	logic [KW-1:0]        end_k;
	logic [PW-1:0]        run_start;

	always_comb begin
		carry     = (work_q | (work_q - ONE_P)) + ONE_P;
		run_mask  = work_q & ~carry;
		run_low   = work_q & (~work_q + ONE_P);
		end_oh    = carry & ~work_q;
		run_start = onehot_idx(run_low);
		end_k     = (|end_oh) ? KW'(onehot_idx(end_oh)) : KW'(MAX_PAGES);
	end

	// consume the registered run, cut short at the pages still wanted
	logic [MAX_PAGES-1:0] part_mask;
	logic                 cut;
	logic [KW-1:0]        take;
	logic [MAX_PAGES-1:0] taken;
	logic [MAX_PAGES-1:0] work_next;
	logic [KW-1:0]        left_next;
	logic                 run_last;

	always_comb begin
		part_mask = ((ONE_P << left_q) - ONE_P) << start_q;
		cut       = (len_q > left_q);
		take      = cut ? left_q : len_q;
		taken     = cut ? part_mask : runm_q;
		work_next = work_q & ~taken;
		left_next = left_q - take;
		run_last  = (left_next == '0);
	end

	// status to the controller
	always_comb begin
		sts.op           = op_q;
		sts.cnt_zero     = cnt_zero;
		sts.no_space     = no_space;
		sts.out_of_range = out_of_range;
		sts.run_last     = run_last;
		sts.too_many     = (int'(runs_q) > MAX_RUNS);
		sts.slot_free    = !out_valid_q || !out_stall;
	end

	// page map, free count and active pages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q    <= RESET_MAP;
			free_q   <= KW'(RESET_ACTIVE);
			active_q <= KW'(RESET_ACTIVE);
		end else if (cfg_we) begin
			map_q    <= cfg_map;
			free_q   <= cfg_n;
			active_q <= cfg_n;
		end else begin
			if (cmd.charge) free_q <= free_q - cnt_q;
			if (cmd.step && cmd.put == PUT_RUN && run_last) map_q <= work_next;
			if (cmd.put == PUT_GROUP) begin
				map_q  <= map_grp;
				free_q <= free_grp;
			end
		end
	end

	// item latch, walk and group registers
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q    <= op_t'(op);
			first_q <= first_page;
			cnt_q   <= KW'(page_count);
		end
		if (cmd.load_walk) begin
			work_q <= map_q;
			left_q <= cnt_q;
			runs_q <= '0;
		end
		if (cmd.find) begin
			runm_q  <= run_mask;
			start_q <= run_start;
			len_q   <= end_k - KW'(run_start);
		end
		if (cmd.step) begin
			work_q <= work_next;
			left_q <= left_next;
			runs_q <= runs_q + RW'(1);
		end
		if (cmd.group_scan) begin
			gmask_q  <= gmask;
			offend_q <= offend_scan;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put != PUT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		case (cmd.put)
			PUT_ZERO, PUT_NO_SPACE, PUT_RANGE: begin
				status_q    <= (cmd.put == PUT_ZERO) ? ST_OK :
				               (cmd.put == PUT_RANGE) ? ST_RANGE : ST_NO_SPACE;
				gfirst_q    <= '0;
				gcount_q    <= '0;
				bad_q       <= '0;
				free_left_q <= PAGE_COUNT_W'(free_q);
				last_q      <= 1'b1;
			end
			PUT_RUN: begin
				status_q    <= ST_OK;
				gfirst_q    <= FIRST_PAGE_W'(start_q);
				gcount_q    <= PAGE_COUNT_W'(take);
				bad_q       <= '0;
				free_left_q <= PAGE_COUNT_W'(free_q);
				last_q      <= run_last;
			end
			PUT_GROUP: begin
				status_q    <= offend_any ? ST_WRONG : ST_OK;
				gfirst_q    <= '0;
				gcount_q    <= '0;
				bad_q       <= offend_any ? FIRST_PAGE_W'(bad_idx) : '0;
				free_left_q <= PAGE_COUNT_W'(free_grp);
				last_q      <= 1'b1;
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign group_first = gfirst_q;
	assign group_count = gcount_q;
	assign bad_page    = bad_q;
	assign free_left   = free_left_q;
	assign last        = last_q;

endmodule
